// File: design/i2p_pkg.sv
// Shared character codes, result type and classification helpers for the
// infix-to-postfix converter. No dependencies.
`default_nettype none

package i2p_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_POW   = 8'h5E;  // ^
   localparam logic [7:0] CH_MUL   = 8'h2A;  // *
   localparam logic [7:0] CH_DIV   = 8'h2F;  // /
   localparam logic [7:0] CH_MOD   = 8'h25;  // %
   localparam logic [7:0] CH_ADD   = 8'h2B;  // +
   localparam logic [7:0] CH_SUB   = 8'h2D;  // -
   localparam logic [7:0] CH_OPEN  = 8'h28;  // (
   localparam logic [7:0] CH_CLOSE = 8'h29;  // )

   // one postfix result before the run-last marker is known
   typedef struct packed {
      logic [7:0] ch;
      logic       term;
      logic       ovf;
   } i2p_result_type;

   function automatic logic [1:0] prec_of(input logic [7:0] ch);
      logic [1:0] p;
      case (ch)
         CH_POW:                 p = 2'd3;
         CH_MUL, CH_DIV, CH_MOD: p = 2'd2;
         CH_ADD, CH_SUB:         p = 2'd1;
         default:                p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_operand(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
             (ch >= "0" && ch <= "9");
   endfunction

   function automatic logic is_skip(input logic [7:0] ch);
      return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_NUL);
   endfunction

   // true when the stacked operator must leave before the incoming one goes on
   function automatic logic pops_over(input logic [7:0] top, input logic [7:0] cur);
      logic [1:0] pt;
      logic [1:0] pc;
      pt = prec_of(top);
      pc = prec_of(cur);
      return (pt > pc) || ((pt == pc) && (cur != CH_POW));
   endfunction

endpackage

`default_nettype wire

// File: design/infix_to_postfix_converter.sv
// Infix-to-postfix converter top level: sequencer, operator stack in RAM,
// output register. Depends on i2p_pkg and i2p_ram.
`default_nettype none

// Takes one infix character per word and emits postfix characters
// (shunting-yard). The operator stack lives in a RAM of STACK_DEPTH bytes
// with a registered read. A word that does not look at the stack goes from
// idle to the finish state. An operator or ')' on a non-empty stack reads the
// top, then pops operators while they leave before it (or until '(' for ')'),
// stalling while the output is full. A word with req_tlast set then flushes
// the stack entry by entry and then emits the zero terminator word.
// A push onto a full stack drops the symbol and sets the sticky overflow flag,
// which clears once the terminator is emitted. rsp_tlast marks the last result
// of each input word. One result is buffered until the next is known, and one
// sits in the output register, so a stalled output holds the sequencer.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // expr_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // [7:0] out_char
   output logic            rsp_tlast,   // run_last
   output logic      [1:0] rsp_tuser    // [0] terminator, [1] overflow_seen
);

   import i2p_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FLUSH,
      ST_FPOP,
      ST_FIN
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [7:0]     ch_ff, ch_in;
   logic           end_ff, end_in;
   logic           hold_valid_ff, hold_valid_in;
   i2p_result_type hold_ff, hold_in;
   logic           rsp_valid_ff, rsp_valid_in;
   i2p_result_type rsp_res_ff, rsp_res_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [7:0]     wr_data, rd_data;

   logic           out_free, can_gen, accept, is_close;
   logic           push_en, gen_en;
   logic [CW-1:0]  push_base, cnt_dec, cnt_dec2;
   logic [7:0]     push_data;
   i2p_result_type gen_data;
   state_type      after_item;

   i2p_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign can_gen    = !hold_valid_ff || out_free;
   assign cnt_dec    = count_ff - CW'(1);
   assign cnt_dec2   = count_ff - CW'(2);
   assign is_close   = (ch_ff == CH_CLOSE);
   assign after_item = end_ff ? ST_FLUSH : ST_FIN;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      ch_in         = ch_ff;
      end_in        = end_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = ch_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_dec[AW-1:0];
      push_en       = 1'b0;
      push_base     = count_ff;
      push_data     = ch_ff;
      gen_en        = 1'b0;
      gen_data      = '{ch: rd_data, term: 1'b0, ovf: ovf_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in  = req_tdata;
               end_in = req_tlast;
               if (is_skip(req_tdata)) begin
                  state_in = req_tlast ? ST_FLUSH : ST_FIN;
               end else if (is_operand(req_tdata)) begin
                  gen_en   = 1'b1;
                  gen_data = '{ch: req_tdata, term: 1'b0, ovf: ovf_ff};
                  state_in = req_tlast ? ST_FLUSH : ST_FIN;
               end else if (req_tdata == CH_OPEN || count_ff == '0) begin
                  // an unmatched close on an empty stack is dropped
                  push_en   = (req_tdata != CH_CLOSE);
                  push_data = req_tdata;
                  state_in  = req_tlast ? ST_FLUSH : ST_FIN;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (rd_data == CH_OPEN) begin
               if (is_close) begin
                  count_in = cnt_dec;
               end else begin
                  push_en = 1'b1;
               end
               state_in = after_item;
            end else if (is_close || pops_over(rd_data, ch_ff)) begin
               if (can_gen) begin
                  gen_en   = 1'b1;
                  count_in = cnt_dec;
                  if (cnt_dec != '0) begin
                     rd_en   = 1'b1;
                     rd_addr = cnt_dec2[AW-1:0];
                  end else begin
                     push_en   = !is_close;
                     push_base = cnt_dec;
                     state_in  = after_item;
                  end
               end
            end else begin
               push_en  = 1'b1;
               state_in = after_item;
            end
         end
         ST_FLUSH: begin
            if (count_ff != '0) begin
               rd_en    = 1'b1;
               state_in = ST_FPOP;
            end else if (can_gen) begin
               gen_en   = 1'b1;
               gen_data = '{ch: CH_NUL, term: 1'b1, ovf: ovf_ff};
               ovf_in   = 1'b0;
               state_in = ST_FIN;
            end
         end
         ST_FPOP: begin
            if (can_gen) begin
               gen_en   = 1'b1;
               count_in = cnt_dec;
               if (cnt_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_dec2[AW-1:0];
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FIN: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_res_in    = hold_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_en) begin
         if (push_base == CW'(STACK_DEPTH)) begin
            ovf_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            wr_addr  = push_base[AW-1:0];
            wr_data  = push_data;
            count_in = push_base + CW'(1);
         end
      end

      // a new result pushes the held one out; it was not the last of the run
      if (gen_en) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = hold_ff;
            rsp_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = gen_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      end_ff      <= end_in;
      hold_ff     <= hold_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_res_ff.ch;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_res_ff.term;
   assign rsp_tuser[1] = rsp_res_ff.ovf;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("result left behind when taking a new word");

   a_term_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.term |-> rsp_last_ff)
      else $error("terminator not marked last");

   a_term_clears_ovf: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && count_ff == '0 && can_gen |=> !ovf_ff)
      else $error("overflow flag survived the terminator");

endmodule

`default_nettype wire

// File: design/i2p_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module i2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: test/infix_to_postfix_converter_tb.sv
// Self-checking testbench for infix_to_postfix_converter: streams infix characters,
// predicts the postfix words with its own operator stack and checks every output word.
// Depends on i2p_pkg and the converter RTL.
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
   import i2p_pkg::*;

   localparam int STACK_DEPTH = 32;
   localparam int IDLE_LIMIT  = 2000;
   localparam int MAX_PRINTED = 40;
   localparam int RANDOM_ITEMS = 380;

   typedef struct {
      logic [7:0] ch;
      bit         expr_end;
   } infix_char_type;

   typedef struct {
      logic [7:0] ch;
      bit         run_last;
      bit         term;
      bit         ovf;
   } postfix_word_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] in_char
   logic       req_tlast;    // expr_end
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] out_char
   logic       rsp_tlast;    // run_last
   logic [1:0] rsp_tuser;    // [0] terminator, [1] overflow_seen

   infix_to_postfix_converter #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // stimulus and expected postfix words
   infix_char_type   pending_chars[$];
   postfix_word_type postfix_words[$];
   infix_char_type   next_char;
   postfix_word_type want_word;
   int            counted_chars;
   int            total_chars;
   int            chars_accepted;
   int            words_checked;
   int            mismatches;
   int            quiet_cycles;

   // shadow of the converter state
   logic [7:0] shadow_stack[STACK_DEPTH];
   int         shadow_depth;
   bit         shadow_ovf;
   int         released;

   // handshake bookkeeping between the monitor and the drivers
   bit req_fired;
   bit rsp_fired;
   bit req_burst;
   bit rsp_burst;
   int req_wait;
   int rsp_stall;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   //---------------------------------------------------------------------------
   // Predictor
   //---------------------------------------------------------------------------
   function automatic logic [1:0] binding_rank(input logic [7:0] ch);
      if (ch == CH_POW) return 2'd3;
      if (ch == CH_MUL || ch == CH_DIV || ch == CH_MOD) return 2'd2;
      if (ch == CH_ADD || ch == CH_SUB) return 2'd1;
      return 2'd0;
   endfunction

   task automatic release_word(input logic [7:0] ch, input bit term);
      postfix_words.push_back('{ch, 1'b0, term, shadow_ovf});
      released++;
   endtask

   task automatic push_symbol(input logic [7:0] ch);
      if (shadow_depth >= STACK_DEPTH) begin
         shadow_ovf = 1'b1;
      end else begin
         shadow_stack[shadow_depth] = ch;
         shadow_depth++;
      end
   endtask

   task automatic convert_char(input logic [7:0] ch, input bit expr_end);
      logic [1:0] rank_in;
      released = 0;
      rank_in  = binding_rank(ch);
      if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_NUL) begin
         // whitespace and NUL are dropped
      end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
                   (ch >= "0" && ch <= "9")) begin
         release_word(ch, 1'b0);
      end else if (ch == CH_OPEN) begin
         push_symbol(ch);
      end else if (ch == CH_CLOSE) begin
         // an unmatched close drains the whole stack
         while (shadow_depth > 0 && shadow_stack[shadow_depth-1] != CH_OPEN) begin
            release_word(shadow_stack[shadow_depth-1], 1'b0);
            shadow_depth--;
         end
         if (shadow_depth > 0) shadow_depth--;
      end else begin
         // only ^ binds right to left
         while (shadow_depth > 0 && shadow_stack[shadow_depth-1] != CH_OPEN &&
                (binding_rank(shadow_stack[shadow_depth-1]) > rank_in ||
                 (binding_rank(shadow_stack[shadow_depth-1]) == rank_in &&
                  ch != CH_POW))) begin
            release_word(shadow_stack[shadow_depth-1], 1'b0);
            shadow_depth--;
         end
         push_symbol(ch);
      end
      if (expr_end) begin
         while (shadow_depth > 0) begin
            release_word(shadow_stack[shadow_depth-1], 1'b0);
            shadow_depth--;
         end
         release_word(8'h00, 1'b1);
         shadow_ovf = 1'b0;
      end
      if (released > 0) postfix_words[postfix_words.size()-1].run_last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch on word %0d, %s: got %02h, expected %02h",
                  words_checked, what, got, want);
   endtask

   //---------------------------------------------------------------------------
   // Stimulus builders
   //---------------------------------------------------------------------------
   task automatic add_char(input logic [7:0] ch, input bit expr_end);
      pending_chars.push_back('{ch, expr_end});
      counted_chars++;
   endtask

   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 2))
         0:       return 8'("a" + $urandom_range(0, 25));
         1:       return 8'("A" + $urandom_range(0, 25));
         default: return 8'("0" + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [7:0] pick_operator();
      logic [7:0] ops[7];
      ops = '{CH_POW, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB, 8'h00};
      // unknown symbols bind loosest of all
      ops[6] = ($urandom_range(0, 1) == 0) ? 8'h3D : 8'($urandom_range(8'h80, 8'hFF));
      return ops[$urandom_range(0, 6)];
   endfunction

   function automatic logic [7:0] pick_blank();
      logic [7:0] blanks[4];
      blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_NUL};
      return blanks[$urandom_range(0, 3)];
   endfunction

   // well-formed expression with random content; broken ones leave '(' open
   // or throw in a stray ')'
   task automatic add_expression(input int terms, input bit broken);
      int open_cnt;
      int k;
      open_cnt = 0;
      for (k = 0; k < terms; k++) begin
         while ($urandom_range(0, 3) == 0 && open_cnt < 6) begin
            add_char(CH_OPEN, 1'b0);
            open_cnt++;
         end
         add_char(pick_operand(), 1'b0);
         while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
            add_char(CH_CLOSE, 1'b0);
            open_cnt--;
         end
         if (broken && $urandom_range(0, 3) == 0) add_char(CH_CLOSE, 1'b0);
         if ($urandom_range(0, 7) == 0) add_char(pick_blank(), 1'b0);
         if (k < terms - 1) add_char(pick_operator(), 1'b0);
      end
      while (open_cnt > 0 && !(broken && $urandom_range(0, 1) == 0)) begin
         add_char(CH_CLOSE, 1'b0);
         open_cnt--;
      end
      pending_chars[pending_chars.size()-1].expr_end = 1'b1;
   endtask

   // deep nesting or a long chain of one operator; nesting or a ^ chain can fill or overrun the stack
   task automatic add_deep(input logic [7:0] sym, input int pushes);
      int k;
      if (sym != CH_OPEN) add_char(pick_operand(), 1'b0);
      for (k = 0; k < pushes; k++) begin
         add_char(sym, 1'b0);
         if (sym != CH_OPEN) add_char(pick_operand(), 1'b0);
      end
      add_char(pick_operand(), 1'b0);
      add_char(CH_ADD, 1'b0);
      add_char(pick_operand(), 1'b1);
   endtask

   //---------------------------------------------------------------------------
   // Sequence
   //---------------------------------------------------------------------------
   initial begin
      int pick;
      int k;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      counted_chars  = 0;
      chars_accepted = 0;
      words_checked  = 0;
      mismatches     = 0;
      quiet_cycles   = 0;
      shadow_depth   = 0;
      shadow_ovf     = 1'b0;
      req_fired = 1'b0;
      rsp_fired = 1'b0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      req_wait  = $urandom_range(0, 18);
      rsp_stall = $urandom_range(0, 18);

      // directed: every operator, right-assoc ^, unknown and high symbols,
      // blanks, stray ')', flush with an open '(' and an end on an empty stack
      add_char(CH_OPEN, 1'b0);
      add_char("A", 1'b0);
      add_char(CH_ADD, 1'b0);
      add_char("9", 1'b0);
      add_char(CH_CLOSE, 1'b0);
      add_char(CH_MUL, 1'b0);
      add_char("z", 1'b0);
      add_char(CH_POW, 1'b0);
      add_char("0", 1'b0);
      add_char(CH_POW, 1'b0);
      add_char("Z", 1'b0);
      add_char(CH_MOD, 1'b0);
      add_char("a", 1'b0);
      add_char(CH_DIV, 1'b0);
      add_char(CH_SPACE, 1'b0);
      add_char("b", 1'b0);
      add_char(CH_SUB, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(CH_CLOSE, 1'b0);
      add_char(CH_TAB, 1'b0);
      add_char(CH_OPEN, 1'b0);
      add_char(8'h80, 1'b0);
      add_char(CH_LF, 1'b0);
      add_char(CH_NUL, 1'b1);
      add_char(CH_CLOSE, 1'b1);

      add_deep(CH_OPEN, $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4));
      add_deep(CH_POW, $urandom_range(STACK_DEPTH, STACK_DEPTH + 3));
      while (counted_chars < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            add_expression($urandom_range(1, 8), 1'b0);
         end else if (pick < 85) begin
            add_expression($urandom_range(1, 8), 1'b1);
         end else if (pick < 98) begin
            for (k = $urandom_range(1, 6); k > 0; k--)
               add_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
         end else begin
            add_deep(pick_operator(), $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2));
         end
      end
      total_chars = pending_chars.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (chars_accepted < total_chars || postfix_words.size() > 0)
         @(posedge clock);
      repeat (STACK_DEPTH + 40) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   //---------------------------------------------------------------------------
   // Input driver
   //---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fired)) begin
         if (req_fired) begin
            req_fired = 1'b0;
            if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
            req_wait = req_burst ? 0 : $urandom_range(0, 18);
         end
         if (req_wait > 0 || pending_chars.size() == 0) begin
            if (req_wait > 0) req_wait--;
            req_tvalid <= 1'b0;
         end else begin
            next_char = pending_chars.pop_front();
            req_tdata  <= next_char.ch;
            req_tlast  <= next_char.expr_end;
            req_tvalid <= 1'b1;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Output back-pressure
   //---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fired) begin
            rsp_fired = 1'b0;
            if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 18);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Monitor, checker and watchdog
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            convert_char(req_tdata, req_tlast);
            req_fired = 1'b1;
            chars_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_fired = 1'b1;
            if (postfix_words.size() == 0) begin
               report_mismatch("word with nothing pending, out_char", rsp_tdata, 8'h00);
            end else begin
               want_word = postfix_words.pop_front();
               if (rsp_tdata !== want_word.ch)
                  report_mismatch("out_char", rsp_tdata, want_word.ch);
               if (rsp_tlast !== want_word.run_last)
                  report_mismatch("run_last", 8'(rsp_tlast), 8'(want_word.run_last));
               if (rsp_tuser[0] !== want_word.term)
                  report_mismatch("terminator", 8'(rsp_tuser[0]), 8'(want_word.term));
               if (rsp_tuser[1] !== want_word.ovf)
                  report_mismatch("overflow_seen", 8'(rsp_tuser[1]), 8'(want_word.ovf));
            end
            words_checked++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

endmodule
